### hdl/lifo_stack_with_match_count_macros.svh
// Assertion macros shared by the stack modules.
`ifndef LIFO_STACK_WITH_MATCH_COUNT_MACROS_SVH
`define LIFO_STACK_WITH_MATCH_COUNT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define LSMC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Checks a same-cycle implication outside reset.
`define LSMC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define LSMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lsmc_pkg.sv
// Types and codes shared by the stack controller, datapath and top level.
package lsmc_pkg;

    localparam int DEPTH_DEFAULT = 8;

    // Operation codes.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;
    localparam logic [1:0] OP_DUMP  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    // Memory read address selection.
    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_TOP   = 2'd1;
    localparam logic [1:0] RD_FIRST = 2'd2;
    localparam logic [1:0] RD_NEXT  = 2'd3;

    // Result payload selection.
    localparam logic [1:0] OUT_ZERO = 2'd0;
    localparam logic [1:0] OUT_MEM  = 2'd1;
    localparam logic [1:0] OUT_HITS = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [3:0]         match_count;
        logic [3:0]         fill_level;
        logic               last;
    } res_t;

    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop;
        logic       step;
        logic [1:0] rd_sel;
        logic       emit;
        logic [1:0] out_sel;
        logic [1:0] status;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic at_top;
        logic hit_any;
    } sts_t;

endpackage

### hdl/lsmc_dp.sv
// Stack datapath: entry memory, fill level, scan index, match counter and result register.
`include "lifo_stack_with_match_count_macros.svh"

module lsmc_dp #(
    parameter int DEPTH = lsmc_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lsmc_pkg::req_t request,
    input  lsmc_pkg::cmd_t cmd,
    output lsmc_pkg::sts_t sts,
    output lsmc_pkg::res_t result,
    output logic          result_strobe
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int EW = LW + 4;

    logic [31:0]        stack_mem [DEPTH];
    logic [31:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;

    logic [LW-1:0]      level_reg, level_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [LW-1:0]      hits_reg, hits_next;
    logic signed [31:0] value_reg, value_next;
    lsmc_pkg::res_t     result_reg, result_next;
    logic               strobe_reg;

    logic               eq;
    logic [LW-1:0]      hits_total;
    logic [EW-1:0]      hits_ext;
    logic [EW-1:0]      level_ext;

    assign eq         = (rd_data_reg == value_reg);
    assign hits_total = hits_reg + LW'(eq);
    assign hits_ext   = EW'(hits_total);
    assign level_ext  = EW'(level_next);

    assign sts.empty   = (level_reg == '0);
    assign sts.full    = (level_reg == LW'(DEPTH));
    assign sts.at_top  = ((LW'(idx_reg) + LW'(1)) == level_reg);
    assign sts.hit_any = (hits_total != '0);

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        unique case (cmd.rd_sel)
            lsmc_pkg::RD_TOP:   rd_addr = AW'(level_reg - LW'(1));
            lsmc_pkg::RD_FIRST: rd_addr = '0;
            lsmc_pkg::RD_NEXT:  rd_addr = idx_reg + AW'(1);
            default:            rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        level_next = level_reg;
        if (cmd.push)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (cmd.pop)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        hits_next  = hits_reg;
        value_next = value_reg;
        if (cmd.load)
        begin
            idx_next   = '0;
            hits_next  = '0;
            value_next = request.value;
        end
        else if (cmd.step)
        begin
            idx_next  = idx_reg + AW'(1);
            hits_next = hits_total;
        end
    end

    always_comb
    begin
        result_next             = '0;
        result_next.status      = cmd.status;
        result_next.fill_level  = level_ext[3:0];
        result_next.last        = cmd.last;
        unique case (cmd.out_sel)
            lsmc_pkg::OUT_MEM:  result_next.data        = rd_data_reg;
            lsmc_pkg::OUT_HITS: result_next.match_count = hits_ext[3:0];
            default:            result_next.data        = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[AW'(level_reg)] <= request.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            level_reg  <= level_next;
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        hits_reg  <= hits_next;
        value_reg <= value_next;
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    `LSMC_ASSERT_ALWAYS(a_level_bound, level_reg <= LW'(DEPTH), "fill level above depth")
    `LSMC_ASSERT_IMPL(a_push_room, cmd.push, !sts.full && !cmd.pop, "push into a full stack")
    `LSMC_ASSERT_NEXT(a_emit_strobe, cmd.emit, result_strobe, "emitted item has no strobe")

endmodule

### hdl/lsmc_ctrl.sv
// Stack controller: accepts requests and sequences pop, count scan and dump.
`include "lifo_stack_with_match_count_macros.svh"

module lsmc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     operation,
    input  lsmc_pkg::sts_t sts,
    output lsmc_pkg::cmd_t cmd,
    output logic           busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0] state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cmd.last = 1'b1;
                    unique case (operation)
                        lsmc_pkg::OP_PUSH:
                        begin
                            cmd.emit = 1'b1;
                            if (sts.full)
                            begin
                                cmd.status = lsmc_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.push   = 1'b1;
                                cmd.status = lsmc_pkg::ST_OK;
                            end
                        end
                        lsmc_pkg::OP_POP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = lsmc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                cmd.rd_sel = lsmc_pkg::RD_TOP;
                                state_next = S_POP;
                            end
                        end
                        lsmc_pkg::OP_COUNT:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = lsmc_pkg::ST_NOMATCH;
                            end
                            else
                            begin
                                cmd.rd_sel = lsmc_pkg::RD_FIRST;
                                state_next = S_SCAN;
                            end
                        end
                        lsmc_pkg::OP_DUMP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.status = lsmc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_sel = lsmc_pkg::RD_FIRST;
                                state_next = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                cmd.emit    = 1'b1;
                cmd.status  = lsmc_pkg::ST_OK;
                cmd.out_sel = lsmc_pkg::OUT_MEM;
                cmd.last    = 1'b1;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                // One stored entry is compared per cycle, bottom to top.
                if (sts.at_top)
                begin
                    cmd.emit    = 1'b1;
                    cmd.status  = sts.hit_any ? lsmc_pkg::ST_OK : lsmc_pkg::ST_NOMATCH;
                    cmd.out_sel = lsmc_pkg::OUT_HITS;
                    cmd.last    = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    cmd.rd_sel = lsmc_pkg::RD_NEXT;
                end
            end
            S_DUMP:
            begin
                cmd.emit    = 1'b1;
                cmd.status  = lsmc_pkg::ST_OK;
                cmd.out_sel = lsmc_pkg::OUT_MEM;
                cmd.last    = sts.at_top;
                if (sts.at_top)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    cmd.rd_sel = lsmc_pkg::RD_NEXT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LSMC_ASSERT_NEXT(a_pop_one_cycle, state_reg == S_POP, state_reg == S_IDLE, "pop did not finish")
    `LSMC_ASSERT_IMPL(a_accept_acts, (state_reg == S_IDLE) && start, cmd.emit || (state_next != S_IDLE), "accepted item ignored")
    `LSMC_ASSERT_IMPL(a_idle_quiet, (state_reg == S_IDLE) && !start, !cmd.emit && !cmd.push && !cmd.pop, "activity with no item")

endmodule

### hdl/lifo_stack_with_match_count.sv
// Top level of the LIFO stack with match counting.
// A request item (operation, value) is taken at a clock edge where start is high and busy is
// low. Results appear on result for one cycle each, marked by result_strobe; the receiver
// cannot stall them and must take every one.
// Push, and any request that hits a full or empty stack, gives one result in the cycle after
// acceptance and leaves busy low, so such items may be issued every cycle.
// Pop reads the top entry on acceptance, then gives its result from the pop state (busy while in it).
// Count compares one stored entry per cycle through the single read port of the entry
// memory, bottom to top: its result comes once the top entry has been compared.
// Dump gives one result per stored entry, bottom to top, in consecutive cycles once the
// first entry has been read, with last set on the top entry.
// A new item may be accepted in the cycle in which the final result of the previous one is
// shown. Every result carries the fill level after the request, in four bits.
// Reset empties the stack; entry memory contents are not cleared and need no clearing pass.
module lifo_stack_with_match_count #(
    parameter int DEPTH = lsmc_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lsmc_pkg::req_t request,
    output lsmc_pkg::res_t result,
    output logic           result_strobe
);

    lsmc_pkg::cmd_t cmd;
    lsmc_pkg::sts_t sts;

    lsmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    lsmc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

### test/lifo_stack_with_match_count_checker.sv
// Checker that predicts every stack result and compares it with what the block returns.
module lifo_stack_with_match_count_checker #(
    parameter int DEPTH = lsmc_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  lsmc_pkg::req_t request,
    input  lsmc_pkg::res_t result,
    input  logic           result_strobe,
    output int             fail_count,
    output int             replies_due
);

    logic signed [31:0] stack_words [DEPTH];
    int                 held;
    int                 mismatches = 0;
    lsmc_pkg::res_t     stack_replies [$];

    function automatic lsmc_pkg::res_t make_reply(logic [1:0] status,
                                                  logic signed [31:0] data,
                                                  int hits, logic last_flag);
        lsmc_pkg::res_t reply;
        reply.status      = status;
        reply.data        = data;
        reply.match_count = hits[3:0];
        reply.fill_level  = held[3:0];
        reply.last        = last_flag;
        return reply;
    endfunction

    task automatic apply_request(input lsmc_pkg::req_t item);
        int hits;
        hits = 0;
        case (item.operation)
            lsmc_pkg::OP_PUSH:
                if (held >= DEPTH)
                begin
                    stack_replies.push_back(make_reply(lsmc_pkg::ST_FULL, '0, 0, 1'b1));
                end
                else
                begin
                    stack_words[held] = item.value;
                    held++;
                    stack_replies.push_back(make_reply(lsmc_pkg::ST_OK, '0, 0, 1'b1));
                end
            lsmc_pkg::OP_POP:
                if (held == 0)
                begin
                    stack_replies.push_back(make_reply(lsmc_pkg::ST_EMPTY, '0, 0, 1'b1));
                end
                else
                begin
                    held--;
                    stack_replies.push_back(make_reply(lsmc_pkg::ST_OK, stack_words[held],
                                                       0, 1'b1));
                end
            lsmc_pkg::OP_COUNT:
            begin
                for (int i = 0; i < held; i++)
                begin
                    if (stack_words[i] == item.value)
                        hits++;
                end
                stack_replies.push_back(make_reply((hits != 0) ? lsmc_pkg::ST_OK :
                                                   lsmc_pkg::ST_NOMATCH, '0, hits, 1'b1));
            end
            default:
                if (held == 0)
                begin
                    stack_replies.push_back(make_reply(lsmc_pkg::ST_EMPTY, '0, 0, 1'b1));
                end
                else
                begin
                    // A dump walks the stack from the bottom entry up to the top one.
                    for (int i = 0; i < held; i++)
                        stack_replies.push_back(make_reply(lsmc_pkg::ST_OK, stack_words[i], 0,
                                                           i == held - 1));
                end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lsmc_pkg::res_t want;
        if (!rst_n)
        begin
            held = 0;
            stack_replies.delete();
            replies_due <= 0;
            fail_count  <= mismatches;
        end
        else
        begin
            // An unknown strobe is treated as a result so that it gets reported.
            if (result_strobe !== 1'b0)
            begin
                if (stack_replies.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with none outstanding: %s %0d %0d %0d %0d %0d",
                                 $realtime, "status/data/count/fill/last",
                                 result.status, result.data, result.match_count,
                                 result.fill_level, result.last);
                    mismatches++;
                end
                else
                begin
                    want = stack_replies.pop_front();
                    if (result.status !== want.status || result.data !== want.data ||
                        result.match_count !== want.match_count ||
                        result.fill_level !== want.fill_level || result.last !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: expected status %0d data %0d count %0d fill %0d last %0d",
                                     $realtime, want.status, want.data, want.match_count,
                                     want.fill_level, want.last);
                            $display("%0t: got      status %0d data %0d count %0d fill %0d last %0d",
                                     $realtime, result.status, result.data,
                                     result.match_count, result.fill_level, result.last);
                        end
                        mismatches++;
                    end
                end
            end
            if (start && busy === 1'b0)
                apply_request(request);
            replies_due <= stack_replies.size();
            fail_count  <= mismatches;
        end
    end

endmodule

### test/tb_lifo_stack_with_match_count.sv
// Stimulus and verdict for the LIFO stack with match counting.
module tb_lifo_stack_with_match_count;

    localparam int DEPTH        = lsmc_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 330;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    lsmc_pkg::req_t request;
    lsmc_pkg::res_t result;
    logic           result_strobe;
    int             fail_count;
    int             replies_due;

    logic signed [31:0] common_values [4];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lifo_stack_with_match_count #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result(result),
        .result_strobe(result_strobe)
    );

    lifo_stack_with_match_count_checker #(
        .DEPTH(DEPTH)
    ) u_stack_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result(result),
        .result_strobe(result_strobe),
        .fail_count(fail_count),
        .replies_due(replies_due)
    );

    // Holds the item on the bus until the block takes it.
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                             input int gap);
        lsmc_pkg::req_t item;
        item.operation = op;
        item.value     = val;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Mostly values from a small set, so that counts find matches.
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return common_values[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    function automatic int pick_gap(bit gappy);
        return gappy ? int'($urandom_range(0, 15)) : 0;
    endfunction

    initial
    begin
        #4_000_000;
        $display("FAIL lifo_stack_with_match_count");
        $finish;
    end

    initial
    begin
        int                 sent;
        int                 mode;
        int                 burst;
        int                 roll;
        bit                 gappy;
        logic [1:0]         op;
        logic signed [31:0] val;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        common_values[0] = $urandom;
        common_values[1] = $urandom;
        common_values[2] = -1;
        common_values[3] = $urandom_range(0, 3);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stack cases first, then fill past the top, then drain past the bottom.
        send_item(lsmc_pkg::OP_DUMP, 32'sd0, 0);
        send_item(lsmc_pkg::OP_POP, 32'sd0, 0);
        send_item(lsmc_pkg::OP_COUNT, 32'sd0, 0);
        send_item(lsmc_pkg::OP_PUSH, 32'h8000_0000, 0);
        send_item(lsmc_pkg::OP_PUSH, 32'h7FFF_FFFF, 1);
        send_item(lsmc_pkg::OP_PUSH, 32'sd0, 0);
        send_item(lsmc_pkg::OP_PUSH, -32'sd1, 0);
        for (int k = 0; k < DEPTH - 4; k++)
            send_item(lsmc_pkg::OP_PUSH, 32'sd5, 0);
        send_item(lsmc_pkg::OP_PUSH, 32'sd123, 0);
        send_item(lsmc_pkg::OP_COUNT, 32'sd5, 0);
        send_item(lsmc_pkg::OP_COUNT, 32'sd7, 0);
        send_item(lsmc_pkg::OP_COUNT, 32'h8000_0000, 2);
        send_item(lsmc_pkg::OP_DUMP, 32'sd0, 0);
        for (int k = 0; k < DEPTH + 1; k++)
            send_item(lsmc_pkg::OP_POP, $urandom, 0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode  = $urandom_range(0, 7);
            burst = $urandom_range(6, 20);
            gappy = ($urandom_range(0, 2) != 0);
            if (mode == 7)
            begin
                // Empty the stack, fill it with one value, then count and dump it.
                val = pick_value();
                for (int k = 0; k < DEPTH + 1; k++)
                    send_item(lsmc_pkg::OP_POP, $urandom, pick_gap(gappy));
                for (int k = 0; k < DEPTH + 1; k++)
                    send_item(lsmc_pkg::OP_PUSH, val, pick_gap(gappy));
                send_item(lsmc_pkg::OP_COUNT, val, pick_gap(gappy));
                send_item(lsmc_pkg::OP_DUMP, $urandom, pick_gap(gappy));
                sent += 2 * DEPTH + 4;
            end
            else
            begin
                for (int k = 0; k < burst; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (mode < 2)
                        op = (roll < 70) ? lsmc_pkg::OP_PUSH :
                             (roll < 85) ? lsmc_pkg::OP_COUNT :
                             (roll < 95) ? lsmc_pkg::OP_DUMP : lsmc_pkg::OP_POP;
                    else if (mode < 4)
                        op = (roll < 60) ? lsmc_pkg::OP_POP :
                             (roll < 75) ? lsmc_pkg::OP_PUSH :
                             (roll < 90) ? lsmc_pkg::OP_COUNT : lsmc_pkg::OP_DUMP;
                    else
                        op = 2'($urandom_range(0, 3));
                    send_item(op, pick_value(), pick_gap(gappy));
                    sent++;
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        wait (replies_due == 0);
        repeat (DEPTH + 6) @(posedge clk);
        if (fail_count == 0)
            $display("PASS lifo_stack_with_match_count");
        else
            $display("FAIL lifo_stack_with_match_count");
        $finish;
    end

endmodule

### lifo_stack_with_match_count.f
+incdir+hdl
hdl/lsmc_pkg.sv
hdl/lsmc_dp.sv
hdl/lsmc_ctrl.sv
hdl/lifo_stack_with_match_count.sv
test/lifo_stack_with_match_count_checker.sv
test/tb_lifo_stack_with_match_count.sv
